// ----- src/spd_pkg.sv -----
`default_nettype none

package spd_pkg;

    // Sizing of the open-quote/bracket stack and the brace counter.
    localparam int STACK_DEPTH = 16;
    localparam int MAX_BRACE   = 255;

    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int BRACE_W = $clog2(MAX_BRACE + 1);

    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;

    // Codes kept on the open stack.
    typedef logic [1:0] open_code_t;
    localparam open_code_t CODE_SINGLE  = 2'd1;
    localparam open_code_t CODE_DOUBLE  = 2'd2;
    localparam open_code_t CODE_BRACKET = 2'd3;

    // End-of-input status codes.
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK       = 3'd0;
    localparam status_t STATUS_BRACE    = 3'd1;
    localparam status_t STATUS_QUOTE    = 3'd2;
    localparam status_t STATUS_OVERFLOW = 3'd4;

    // Characters with a meaning to the delimiter.
    typedef logic [CHAR_W-1:0] char_t;
    localparam char_t CH_SQUOTE    = 8'h27;
    localparam char_t CH_DQUOTE    = 8'h22;
    localparam char_t CH_HASH      = 8'h23;
    localparam char_t CH_LBRACE    = 8'h7B;
    localparam char_t CH_RBRACE    = 8'h7D;
    localparam char_t CH_LBRACKET  = 8'h5B;
    localparam char_t CH_RBRACKET  = 8'h5D;
    localparam char_t CH_BACKSLASH = 8'h5C;

endpackage

`default_nettype wire

// ----- src/shell_phrase_delimiter_core.sv -----
// Results are registered. Throughput: one character per cycle while m_axis_tready
// is high; all phrase state is updated in the cycle of the input transfer, and the
// result register frees when taken.
// Reset: aresetn is synchronous and active low; it clears all quote, brace,
// stack, comment, escape and overflow state and empties the result register.
`default_nettype none

module shell_phrase_delimiter_core
    import spd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // last_in_line
    input  wire logic [1:0]  s_axis_tuser,   // [0] has_char, [1] end_of_input

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [10:8] status, zero pad
    output logic             m_axis_tlast,   // phrase_end
    output logic [1:0]       m_axis_tuser    // [0] keep_char, [1] append_newline
);

    // Input fields.
    char_t in_char;
    logic  in_has;
    logic  in_last;
    logic  in_eoi;
    logic  s_accept;

    assign in_char  = s_axis_tdata;
    assign in_has   = s_axis_tuser[0];
    assign in_eoi   = s_axis_tuser[1];
    assign in_last  = s_axis_tlast;

    // Phrase state.
    logic               in_single_reg,      in_single_next;
    logic               in_double_reg,      in_double_next;
    logic [BRACE_W-1:0] brace_depth_reg,    brace_depth_next;
    logic [CNT_W-1:0]   stack_count_reg,    stack_count_next;
    logic               comment_skip_reg,   comment_skip_next;
    logic               escape_pending_reg, escape_pending_next;
    logic               overflowed_reg,     overflowed_next;
    open_code_t         open_stack_reg [STACK_DEPTH];

    // Stack write request and top-of-stack read.
    logic             push_en;
    open_code_t       push_code;
    logic [CNT_W-1:0] top_pos;
    open_code_t       top_code;

    // Result register.
    logic             out_valid_reg;
    char_t            out_char_reg,   out_char_next;
    logic             keep_reg,       keep_next;
    logic             newline_reg,    newline_next;
    logic             done_reg,       done_next;
    status_t          status_reg,     status_next;
    logic             dropped;

    // The result register accepts a new item whenever it is empty or being drained.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign top_pos  = stack_count_reg - CNT_W'(1);
    assign top_code = open_stack_reg[top_pos[IDX_W-1:0]];

    // Per-character update of the phrase state and the result fields.
    always_comb begin
        in_single_next      = in_single_reg;
        in_double_next      = in_double_reg;
        brace_depth_next    = brace_depth_reg;
        stack_count_next    = stack_count_reg;
        comment_skip_next   = comment_skip_reg;
        escape_pending_next = escape_pending_reg;
        overflowed_next     = overflowed_reg;
        push_en             = 1'b0;
        push_code           = CODE_SINGLE;
        out_char_next       = '0;
        keep_next           = 1'b0;
        newline_next        = 1'b0;
        done_next           = 1'b0;
        status_next         = STATUS_OK;
        dropped             = 1'b0;

        if (in_eoi) begin
            // Report what is still open, then return to the reset state.
            if (overflowed_reg) begin
                status_next = STATUS_OVERFLOW;
            end else begin
                status_next = ((brace_depth_reg != '0) ? STATUS_BRACE : STATUS_OK)
                            | ((stack_count_reg != '0) ? STATUS_QUOTE : STATUS_OK);
            end
            in_single_next      = 1'b0;
            in_double_next      = 1'b0;
            brace_depth_next    = '0;
            stack_count_next    = '0;
            comment_skip_next   = 1'b0;
            escape_pending_next = 1'b0;
            overflowed_next     = 1'b0;
        end else begin
            if (in_has) begin
                keep_next     = 1'b1;
                out_char_next = in_char;
                if (escape_pending_reg) begin
                    escape_pending_next = 1'b0;
                end else if (!comment_skip_reg) begin
                    priority if (in_char == CH_SQUOTE && !in_double_reg
                                 && brace_depth_reg == '0) begin
                        if (!in_single_reg) begin
                            push_code = CODE_SINGLE;
                            push_en   = 1'b1;
                        end else if (stack_count_reg != '0) begin
                            stack_count_next = top_pos;
                        end
                        in_single_next = !in_single_reg;
                    end else if (in_char == CH_DQUOTE && !in_single_reg
                                 && brace_depth_reg == '0) begin
                        if (!in_double_reg) begin
                            push_code = CODE_DOUBLE;
                            push_en   = 1'b1;
                        end else if (stack_count_reg != '0) begin
                            stack_count_next = top_pos;
                        end
                        in_double_next = !in_double_reg;
                    end else if (in_char == CH_LBRACKET && brace_depth_reg == '0) begin
                        push_code = CODE_BRACKET;
                        push_en   = 1'b1;
                    end else if (in_char == CH_RBRACKET && brace_depth_reg == '0) begin
                        if (stack_count_reg != '0 && top_code == CODE_BRACKET) begin
                            stack_count_next = top_pos;
                        end
                    end else if (in_char == CH_LBRACE && !in_single_reg
                                 && !in_double_reg) begin
                        if (brace_depth_reg >= BRACE_W'(MAX_BRACE)) begin
                            brace_depth_next = BRACE_W'(MAX_BRACE);
                            overflowed_next  = 1'b1;
                        end else begin
                            brace_depth_next = brace_depth_reg + BRACE_W'(1);
                        end
                    end else if (in_char == CH_RBRACE && !in_single_reg
                                 && !in_double_reg) begin
                        if (brace_depth_reg != '0) begin
                            brace_depth_next = brace_depth_reg - BRACE_W'(1);
                        end
                    end else if (in_char == CH_HASH && !in_single_reg && !in_double_reg
                                 && brace_depth_reg == '0) begin
                        comment_skip_next = 1'b1;
                    end else if (in_char == CH_BACKSLASH) begin
                        if (in_last) begin
                            keep_next = 1'b0;
                            dropped   = 1'b1;
                        end else begin
                            escape_pending_next = 1'b1;
                        end
                    end else begin
                        // Ordinary character: nothing to track.
                    end
                end
            end

            // A full stack ignores the push and flags the overflow.
            if (push_en) begin
                if (stack_count_reg >= CNT_W'(STACK_DEPTH)) begin
                    push_en         = 1'b0;
                    overflowed_next = 1'b1;
                end else begin
                    stack_count_next = stack_count_reg + CNT_W'(1);
                end
            end

            // At a line end, decide whether the phrase is complete.
            if (in_last) begin
                comment_skip_next   = 1'b0;
                escape_pending_next = 1'b0;
                if (!dropped && brace_depth_next == '0 && stack_count_next == '0) begin
                    done_next        = 1'b1;
                    in_single_next   = 1'b0;
                    in_double_next   = 1'b0;
                    brace_depth_next = '0;
                    stack_count_next = '0;
                end else if (!dropped) begin
                    newline_next = 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_single_reg      <= 1'b0;
            in_double_reg      <= 1'b0;
            brace_depth_reg    <= '0;
            stack_count_reg    <= '0;
            comment_skip_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            overflowed_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                in_single_reg      <= in_single_next;
                in_double_reg      <= in_double_next;
                brace_depth_reg    <= brace_depth_next;
                stack_count_reg    <= stack_count_next;
                comment_skip_reg   <= comment_skip_next;
                escape_pending_reg <= escape_pending_next;
                overflowed_reg     <= overflowed_next;
                out_valid_reg      <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stack storage and result payload.
    always_ff @(posedge aclk) begin
        if (s_accept && push_en) begin
            open_stack_reg[stack_count_reg[IDX_W-1:0]] <= push_code;
        end
        if (s_accept) begin
            out_char_reg <= out_char_next;
            keep_reg     <= keep_next;
            newline_reg  <= newline_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, status_reg, out_char_reg};
    assign m_axis_tlast  = done_reg;
    assign m_axis_tuser  = {newline_reg, keep_reg};

`ifndef SYNTHESIS
    // The stack never counts past its depth.
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stack_count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // Single and double quote modes exclude each other.
    a_quote_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_single_reg && in_double_reg))
        else $error("both quote flags set");

    // A completed phrase never also asks for a joining newline.
    a_end_no_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser[1])
        else $error("phrase end with newline");

    // A nonzero status comes only with an otherwise empty result.
    a_status_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[10:8] != STATUS_OK)
        |-> (m_axis_tdata[7:0] == '0 && !m_axis_tlast && m_axis_tuser == 2'b00))
        else $error("status with nonempty result");

    // End of input leaves all phrase state cleared.
    a_eoi_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_eoi) |=> (brace_depth_reg == '0 && stack_count_reg == '0
                                  && !overflowed_reg && !in_single_reg && !in_double_reg))
        else $error("state not cleared after end of input");
`endif

endmodule

`default_nettype wire
